FILE: src/bcfe_pkg.sv
// Package for the bit cell to flux interval encoder.
// Widths, register indexes, event codes and the accumulator command type.
// No dependencies.
package bcfe_pkg;

  localparam int INTERVAL_BITS = 32;
  localparam int TOTAL_BITS    = 48;

  localparam int CLK_W     = 27;
  localparam int VALUE_W   = 48;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = CLK_W;

  // remainder always stays below the divisor, so it fits the clock width
  localparam int REM_W = CLK_W;
  localparam int SUM_W = REM_W + 1;
  localparam int CNT_W = $clog2(SUM_W);

  // saturating interval add is done one bit wider than either operand
  localparam int ACC_W = ((INTERVAL_BITS > SUM_W) ? INTERVAL_BITS : SUM_W) + 1;

  localparam logic [CLK_W-1:0] DEST_CLOCK_RESET   = CLK_W'(24000000);
  localparam logic [CLK_W-1:0] SOURCE_CLOCK_RESET = CLK_W'(500000);

  localparam logic [CFG_IDX_W-1:0] CFG_DEST_CLOCK   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_CLOCK = 1'b1;

  localparam logic EV_PULSE = 1'b0;
  localparam logic EV_INDEX = 1'b1;

  typedef struct packed {
    logic add_quot;
    logic take_pulse;
  } accum_cmd_t;

endpackage

FILE: src/bcfe_stream_if.sv
// Stream interfaces for the encoder's input cells and output events.
// Depends on bcfe_pkg for the event value width.
interface bcfe_in_if;
  logic valid;
  logic ready;
  logic cell_bit;
  logic track_end;

  modport source (output valid, output cell_bit, output track_end, input ready);
  modport sink   (input valid, input cell_bit, input track_end, output ready);
endinterface

interface bcfe_out_if;
  logic                        valid;
  logic                        ready;
  logic                        event_kind;
  logic [bcfe_pkg::VALUE_W-1:0] event_value;
  logic                        last_of_run;

  modport source (output valid, output event_kind, output event_value,
                  output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input event_value,
                  input last_of_run, output ready);
endinterface

FILE: src/bit_cell_to_flux_interval_encoder.sv
// Bit cell to flux interval encoder, top level.
// Depends on bcfe_pkg, bcfe_stream_if, bcfe_divider and bcfe_accum.
//
//   channel  direction  handshake            payload
//   in_ch    sink       valid/ready          cell_bit, track_end
//   out_ch   source     valid/ready          event_kind, event_value, last_of_run
//   cfg      write      cfg_we               cfg_idx, cfg_data
//
// An accepted cell runs through the 28-step bit-serial divider in S_DIV;
// a cell that causes a pulse or index then issues it from S_PULSE, then
// S_INDEX, when the output is free, and one that causes none goes to S_IDLE.
// Reset (synchronous, rst_n low) clears the remainder, interval, total and
// restores the clock registers. A stalled output holds its event; the next
// cell is taken while the last event still waits.
module bit_cell_to_flux_interval_encoder (
  input  logic                           clk,
  input  logic                           rst_n,
  bcfe_in_if.sink                        in_ch,
  bcfe_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [bcfe_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bcfe_pkg::CFG_W-1:0]     cfg_data
);
  import bcfe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_PULSE = 4'b0100,
    S_INDEX = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CLK_W-1:0] dest_r, dest_nxt;
  logic [CLK_W-1:0] source_r, source_nxt;
  logic [CLK_W-1:0] divisor;
  logic             bit_r, bit_nxt;
  logic             end_r, end_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               kind_r, kind_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic               last_r, last_nxt;
  logic               out_free;

  logic                     accept;
  logic                     div_done;
  logic [SUM_W-1:0]         quot;
  accum_cmd_t               cmd;
  logic [INTERVAL_BITS-1:0] interval;
  logic [TOTAL_BITS-1:0]    index_sum;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  // zero source clock divides as one
  assign divisor     = (source_r == '0) ? CLK_W'(1) : source_r;

  bcfe_divider u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept),
    .dest_clock (dest_r),
    .divisor    (divisor),
    .done       (div_done),
    .quot       (quot)
  );

  bcfe_accum u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .quot      (quot),
    .interval  (interval),
    .index_sum (index_sum)
  );

  always_comb begin
    dest_nxt   = dest_r;
    source_nxt = source_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_DEST_CLOCK:   dest_nxt   = cfg_data;
        CFG_SOURCE_CLOCK: source_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    bit_nxt        = bit_r;
    end_nxt        = end_r;
    cmd.add_quot   = 1'b0;
    cmd.take_pulse = 1'b0;
    kind_nxt       = kind_r;
    value_nxt      = value_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          bit_nxt   = in_ch.cell_bit;
          end_nxt   = in_ch.track_end;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          cmd.add_quot = 1'b1;
          if (bit_r) begin
            state_nxt = S_PULSE;
          end else if (end_r) begin
            state_nxt = S_INDEX;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_PULSE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          kind_nxt       = EV_PULSE;
          value_nxt      = VALUE_W'(interval);
          last_nxt       = !end_r;
          cmd.take_pulse = 1'b1;
          state_nxt      = end_r ? S_INDEX : S_IDLE;
        end
      end
      S_INDEX: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = EV_INDEX;
          value_nxt     = VALUE_W'(index_sum);
          last_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dest_r      <= DEST_CLOCK_RESET;
      source_r    <= SOURCE_CLOCK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dest_r      <= dest_nxt;
      source_r    <= source_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r   <= bit_nxt;
    end_r   <= end_nxt;
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_kind  = kind_r;
  assign out_ch.event_value = value_r;
  assign out_ch.last_of_run = last_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && (state_r == S_PULSE || state_r == S_INDEX))
      |=> state_r == $past(state_r))
    else $error("event emitted over a pending transaction");

endmodule

FILE: src/bcfe_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Holds the phase remainder between cells. Depends on bcfe_pkg.
module bcfe_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bcfe_pkg::CLK_W-1:0]   dest_clock,
  input  logic [bcfe_pkg::CLK_W-1:0]   divisor,
  output logic                         done,
  output logic [bcfe_pkg::SUM_W-1:0]   quot
);
  import bcfe_pkg::*;

  logic [SUM_W-1:0] dvd_r, dvd_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [SUM_W-1:0] trial;
  logic [REM_W-1:0] diff;
  logic             ge;

  assign trial = {rem_r, dvd_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  // only the low bits survive when the trial clears the divisor
  assign diff  = trial[REM_W-1:0] - divisor;

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // dividend is the kept remainder plus one cell's worth of flux ticks
      dvd_nxt  = {1'b0, rem_r} + {1'b0, dest_clock};
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(SUM_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff : trial[REM_W-1:0];
      // shift the dividend out and the quotient in
      dvd_nxt = {dvd_r[SUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
  end

  assign done = done_r;
  assign quot = dvd_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && busy_r))
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

endmodule

FILE: src/bcfe_accum.sv
// Flux interval and elapsed total accumulator.
// Saturating interval add, total update on a pulse. Depends on bcfe_pkg.
module bcfe_accum (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bcfe_pkg::accum_cmd_t               cmd,
  input  logic [bcfe_pkg::SUM_W-1:0]         quot,
  output logic [bcfe_pkg::INTERVAL_BITS-1:0] interval,
  output logic [bcfe_pkg::TOTAL_BITS-1:0]    index_sum
);
  import bcfe_pkg::*;

  localparam logic [INTERVAL_BITS-1:0] IMASK = '1;

  logic [INTERVAL_BITS-1:0] interval_r, interval_nxt;
  logic [TOTAL_BITS-1:0]    total_r, total_nxt;
  logic [ACC_W-1:0]         acc_sum;

  assign acc_sum   = ACC_W'(interval_r) + ACC_W'(quot);
  assign index_sum = total_r + TOTAL_BITS'(interval_r);

  always_comb begin
    interval_nxt = interval_r;
    total_nxt    = total_r;
    if (cmd.add_quot) begin
      // clamp at all ones
      interval_nxt = (acc_sum >= ACC_W'(IMASK)) ? IMASK : acc_sum[INTERVAL_BITS-1:0];
    end else if (cmd.take_pulse) begin
      total_nxt    = index_sum;
      interval_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= '0;
      total_r    <= '0;
    end else begin
      interval_r <= interval_nxt;
      total_r    <= total_nxt;
    end
  end

  assign interval = interval_r;

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.add_quot && cmd.take_pulse))
    else $error("add and pulse commands together");

  a_pulse_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_pulse |=> interval_r == '0)
    else $error("interval not cleared after pulse");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the bit cell to flux interval encoder.
// Depends on bcfe_pkg, the stream interfaces in bcfe_stream_if and the encoder RTL.
`timescale 1ns / 1ps
module testbench;
  import bcfe_pkg::*;

  localparam int          SETTLE     = 40;   // cycles past the last event before a write
  localparam int          HOLD_LONG  = 400;  // receiver hold-off under pressure
  localparam int          QUIET_MAX  = 3000; // cycles without a transaction before timeout
  localparam logic [63:0] IV_MAX     = (64'd1 << INTERVAL_BITS) - 64'd1;

  typedef struct {
    logic flux;
    logic last_cell;
  } bit_cell_t;

  typedef struct {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } flux_event_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  bcfe_in_if  in_if ();
  bcfe_out_if out_if ();

  bit_cell_to_flux_interval_encoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // encoder model state
  logic [CLK_W-1:0]         dest_hz;
  logic [CLK_W-1:0]         src_hz;
  logic [31:0]              phase_rem;
  logic [INTERVAL_BITS-1:0] open_iv;
  logic [TOTAL_BITS-1:0]    elapsed;

  bit_cell_t   pending_cells[$];
  flux_event_t expected_events[$];

  int unsigned err_count;
  int unsigned cells_taken;
  int unsigned pulses_seen;
  int unsigned indexes_seen;
  int unsigned saturations;
  int unsigned clock_settings;
  bit          src_gaps_on;
  bit          snk_gaps_on;
  bit          stall_req;
  bit          stall_ack;
  int unsigned stall_left;
  int unsigned src_wait;
  int unsigned snk_wait;
  int unsigned quiet;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned draw_gap(input bit enabled);
    int unsigned r;
    r = $urandom_range(99);
    if (!enabled || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    err_count++;
  endtask

  // Advance the model by one cell and queue the events it causes.
  task automatic encode_cell(input logic flux, input logic last_cell);
    logic [63:0] divisor;
    logic [63:0] sum;
    logic [63:0] quot;
    divisor   = (src_hz == '0) ? 64'd1 : 64'(src_hz);
    sum       = 64'(phase_rem) + 64'(dest_hz);
    quot      = sum / divisor;
    phase_rem = 32'(sum % divisor);
    if (quot >= IV_MAX || 64'(open_iv) >= IV_MAX - quot) begin
      open_iv = IV_MAX[INTERVAL_BITS-1:0];
      saturations++;
    end else begin
      open_iv = open_iv + INTERVAL_BITS'(quot);
    end
    if (flux) begin
      expected_events.push_back('{EV_PULSE, VALUE_W'(open_iv), !last_cell});
      elapsed = elapsed + TOTAL_BITS'(open_iv);
      open_iv = '0;
    end
    if (last_cell)
      expected_events.push_back('{EV_INDEX, VALUE_W'(elapsed + TOTAL_BITS'(open_iv)), 1'b1});
  endtask

  // Driver: offer queued cells, hold while stalled.
  always @(posedge clk) begin : driver
    bit_cell_t c;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      src_wait    <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        encode_cell(in_if.cell_bit, in_if.track_end);
        cells_taken++;
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the offered transaction
      end else if (src_wait != 0) begin
        src_wait    <= src_wait - 1;
        in_if.valid <= 1'b0;
      end else if (pending_cells.size() != 0) begin
        c = pending_cells.pop_front();
        in_if.valid     <= 1'b1;
        in_if.cell_bit  <= c.flux;
        in_if.track_end <= c.last_cell;
        src_wait        <= draw_gap(src_gaps_on);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each event with the oldest expectation, and pace ready.
  always @(posedge clk) begin : monitor
    flux_event_t due;
    int unsigned gap;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
      snk_wait     <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (out_if.event_kind == EV_PULSE) pulses_seen++;
        else indexes_seen++;
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event kind=%0d value=%0d last=%0d",
                                    out_if.event_kind, out_if.event_value,
                                    out_if.last_of_run));
        end else begin
          due = expected_events.pop_front();
          if (out_if.event_kind !== due.kind)
            report_mismatch($sformatf("event_kind %0d, expected %0d",
                                      out_if.event_kind, due.kind));
          if (out_if.event_value !== due.value)
            report_mismatch($sformatf("event_value %0d, expected %0d",
                                      out_if.event_value, due.value));
          if (out_if.last_of_run !== due.last)
            report_mismatch($sformatf("last_of_run %0d, expected %0d",
                                      out_if.last_of_run, due.last));
        end
      end
      if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else if (stall_req != stall_ack) begin
        stall_ack    <= stall_req;
        stall_left   <= HOLD_LONG;
        out_if.ready <= 1'b0;
      end else if (snk_wait != 0) begin
        snk_wait     <= snk_wait - 1;
        out_if.ready <= 1'b0;
      end else begin
        gap = draw_gap(snk_gaps_on);
        if (gap != 0) snk_wait <= gap - 1;
        out_if.ready <= (gap == 0);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_MAX) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic queue_cell(input logic flux, input logic last_cell);
    pending_cells.push_back('{flux, last_cell});
  endtask

  task automatic queue_random(input int unsigned n, input int unsigned one_pct,
                              input int unsigned end_pct);
    repeat (n) queue_cell($urandom_range(99) < one_pct, $urandom_range(99) < end_pct);
  endtask

  // Wait until every queued cell is taken and every event has come.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_cells.size() != 0 || in_if.valid || expected_events.size() != 0)
      @(negedge clk);
  endtask

  // Cells that cause no event may still be in the divider: let it finish.
  task automatic settle();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_clocks(input logic [CLK_W-1:0] dest, input logic [CLK_W-1:0] src);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_DEST_CLOCK;
    cfg_data <= dest;
    @(posedge clk);
    cfg_idx  <= CFG_SOURCE_CLOCK;
    cfg_data <= src;
    @(posedge clk);
    cfg_we   <= 1'b0;
    dest_hz = dest;
    src_hz  = src;
    clock_settings++;
  endtask

  task automatic random_phase(input logic [CLK_W-1:0] dest, input logic [CLK_W-1:0] src,
                              input int unsigned n, input int unsigned one_pct,
                              input int unsigned end_pct, input bit gaps);
    set_clocks(dest, src);
    src_gaps_on = gaps;
    snk_gaps_on = gaps;
    queue_random(n, one_pct, end_pct);
    settle();
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.cell_bit  = 1'b0;
    in_if.track_end = 1'b0;
    out_if.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_DEST_CLOCK;
    cfg_data        = '0;
    rst_n           = 1'b0;
    dest_hz         = DEST_CLOCK_RESET;
    src_hz          = SOURCE_CLOCK_RESET;
    phase_rem       = '0;
    open_iv         = '0;
    elapsed         = '0;
    src_gaps_on     = 1'b1;
    snk_gaps_on     = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset clocks: every flag combination
    queue_cell(0, 0); queue_cell(1, 0); queue_cell(0, 1);
    queue_cell(1, 1); queue_cell(0, 0); queue_cell(1, 0);
    settle();
    // leave a large remainder behind
    set_clocks(27'd99999999, 27'd100000000);
    queue_cell(0, 0); queue_cell(1, 0);
    settle();
    // shrink the divisor far below the kept remainder
    set_clocks(27'd1, 27'd3);
    queue_cell(0, 0); queue_cell(1, 1);
    settle();
    // zero destination clock adds nothing
    set_clocks(27'd0, 27'd5);
    queue_cell(0, 0); queue_cell(1, 0); queue_cell(0, 1);
    settle();
    // zero source clock divides by one
    set_clocks('1, 27'd0);
    queue_cell(0, 0); queue_cell(0, 0); queue_cell(0, 0); queue_cell(1, 1);
    settle();

    // receiver holds off while the sender keeps offering
    set_clocks(DEST_CLOCK_RESET, SOURCE_CLOCK_RESET);
    queue_random(100, 30, 5);
    @(negedge clk);
    stall_req = ~stall_req;
    settle();

    random_phase(CLK_W'($urandom_range(100000000, 1)),
                 CLK_W'($urandom_range(100000000, 1)), 80, 40, 8, 1'b1);
    // drive the interval into saturation
    random_phase('1, 27'd0, 80, 2, 3, 1'b0);
    random_phase(27'd1, '1, 60, 50, 10, 1'b1);
    random_phase(CLK_W'($urandom), CLK_W'($urandom_range(1000, 1)), 80, 30, 5, 1'b1);
    random_phase(27'd0, CLK_W'($urandom), 20, 50, 20, 1'b0);
    random_phase(CLK_W'($urandom), CLK_W'($urandom), 80, 35, 6, 1'b1);

    // pause the sender halfway until every event has come
    set_clocks(27'd48000000, 27'd1000000);
    queue_random(50, 25, 4);
    wait_drained();
    queue_random(50, 25, 4);
    settle();

    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d events never arrived", expected_events.size()));
    $display("Ran %0d cells under %0d clock settings: %0d pulses, %0d indexes checked,",
             cells_taken, clock_settings, pulses_seen, indexes_seen);
    $display("including zero clocks, remainder carry-over and %0d saturated cells.",
             saturations);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
